// ----- src/mcg_pkg.sv -----
// Package for the month calendar grid generator: request record passed from
// front to back, calendar tables and small helper functions. No dependencies.
package mcg_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned COL_W    = 3;
    localparam int unsigned CELL_W   = 6;
    localparam int unsigned QDEPTH   = 2;

    localparam logic [YEAR_W-1:0]  BASE_YEAR   = 14'd1582;
    localparam logic [COL_W-1:0]   LAST_COL    = 3'd6;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;
    // Reciprocal of 100 scaled by 2^19; exact for every 14-bit dividend.
    localparam logic [12:0]        RECIP_100   = 13'd5243;
    localparam int unsigned        RECIP_SHIFT = 19;
    // Day count offset: leap years up to 1581, day zero and the weekday of 1 Jan 1582.
    localparam logic [15:0]        DAY_OFFSET  = 16'd1959;

    typedef struct packed {
        logic [COL_W-1:0] lead;
        logic [DAY_W-1:0] ndays;
    } grid_req_t;

    // Days before the month in a common year, reduced modulo 7.
    function automatic logic [COL_W-1:0] month_shift(input logic [MONTH_W-1:0] m);
        logic [COL_W-1:0] r;
        case (m)
            4'd1:    r = 3'd0;
            4'd2:    r = 3'd3;
            4'd3:    r = 3'd3;
            4'd4:    r = 3'd6;
            4'd5:    r = 3'd1;
            4'd6:    r = 3'd4;
            4'd7:    r = 3'd6;
            4'd8:    r = 3'd2;
            4'd9:    r = 3'd5;
            4'd10:   r = 3'd0;
            4'd11:   r = 3'd3;
            4'd12:   r = 3'd5;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4:    r = 5'd30;
            4'd6:    r = 5'd30;
            4'd9:    r = 5'd30;
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    // Modulo 7 by summing octal digits, since 8 is 1 modulo 7.
    function automatic logic [COL_W-1:0] mod7(input logic [15:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = {3'd0, x[2:0]} + {3'd0, x[5:3]} + {3'd0, x[8:6]} + {3'd0, x[11:9]}
           + {3'd0, x[14:12]} + {5'd0, x[15]};
        s2 = {1'b0, s1[2:0]} + {1'b0, s1[5:3]};
        if (s2 >= 4'd7)
            s2 = s2 - 4'd7;
        return s2[COL_W-1:0];
    endfunction

endpackage

// ----- src/month_calendar_grid_generator_top.sv -----
// Top level of the month calendar grid generator.
// Instantiates mcg_front, mcg_queue and mcg_back; uses mcg_pkg.
//
// Usage:
//   A request is one transfer on the s_axis channel carrying a year and a
//   month. The block answers with one m_axis transfer per grid cell: seven
//   cells a row, blank cells (day 0) before the 1st, the days of the month,
//   then blanks until the row is complete. The weekday of the 1st follows
//   the proleptic Gregorian calendar, Sunday being column 0. m_axis_tlast
//   marks the final cell of each grid; a grid has 28, 35 or 42 cells.
//   Requests with a month outside 1 to 12 or a year before 1582 are taken
//   and discarded without any output.
// Flow and throughput:
//   The front part takes a request through its states in order (accept,
//   reciprocal multiply by 1/100, day count, modulo-7 reduction and
//   hand-over to the queue) and takes no new request before the hand-over.
//   The back part emits one cell per cycle while the receiver accepts
//   cells, and pops a new request only once a grid is complete; the back
//   part sets the sustained rate. A two-entry queue lets the front take
//   further requests while a grid is still being emitted.
// Reset and stalls:
//   rst_n clears the state machines, the queue and the output valid flag.
//   When the receiver holds m_axis_tready low the current cell is held and
//   the back part waits; the queue then fills and s_axis_tready drops.
module month_calendar_grid_generator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [13:0] year_value, [17:14] month_value, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [4:0] cell_day, [7:5] cell_column, [8] row_end, rest zero
    output logic        m_axis_tlast    // grid_last
);
    import mcg_pkg::*;

    logic               push, pop, full, empty;
    grid_req_t          push_req, pop_req;
    logic [DAY_W-1:0]   cell_day;
    logic [COL_W-1:0]   cell_column;
    logic               row_end;

    mcg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .year_value  (s_axis_tdata[13:0]),
        .month_value (s_axis_tdata[17:14]),
        .push        (push),
        .push_req    (push_req),
        .queue_full  (full)
    );

    mcg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .full     (full),
        .pop      (pop),
        .pop_req  (pop_req),
        .empty    (empty)
    );

    mcg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .pop_req     (pop_req),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .cell_day    (cell_day),
        .cell_column (cell_column),
        .row_end     (row_end),
        .grid_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, row_end, cell_column, cell_day};

endmodule

// ----- src/mcg_front.sv -----
// Front part: accepts year/month requests, drops invalid ones and works out the
// weekday of the 1st and the month length in its state sequence. Uses mcg_pkg.
module mcg_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [mcg_pkg::YEAR_W-1:0]  year_value,
    input  logic [mcg_pkg::MONTH_W-1:0] month_value,
    output logic                     push,
    output mcg_pkg::grid_req_t       push_req,
    input  logic                     queue_full
);
    import mcg_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_SUM, F_PUSH} front_state_t;

    front_state_t         state_reg, state_next;
    logic [YEAR_W-1:0]    prev_year_reg, prev_year_next;   // year minus one
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [YEAR_W-1:0]    cent_reg, cent_next;             // (year-1) / 100
    logic [15:0]          count_reg, count_next;
    logic [DAY_W-1:0]     ndays_reg, ndays_next;

    logic                 in_ok;
    logic [26:0]          product;
    logic [YEAR_W-1:0]    cent_x100;
    logic [6:0]           rem100;
    logic                 leap;
    logic [15:0]          leaps;

    assign in_ready = (state_reg == F_IDLE);
    assign in_ok    = (month_value != '0) && (month_value <= MONTH_DEC)
                   && (year_value >= BASE_YEAR);

    assign product   = prev_year_reg * RECIP_100;
    assign cent_x100 = (cent_reg << 6) + (cent_reg << 5) + (cent_reg << 2);
    assign rem100    = 7'(prev_year_reg - cent_x100);
    // The year is a leap year when year-1 ends in ...3 (divisible by 4 next),
    // except at centuries, which count only when divisible by 400.
    assign leap = (rem100 == 7'd99) ? (cent_reg[1:0] == 2'b11)
                                    : (prev_year_reg[1:0] == 2'b11);
    assign leaps = {4'd0, prev_year_reg[YEAR_W-1:2]} - {2'd0, cent_reg}
                 + {4'd0, cent_reg[YEAR_W-1:2]};

    assign push           = (state_reg == F_PUSH) && !queue_full;
    assign push_req.lead  = mod7(count_reg);
    assign push_req.ndays = ndays_reg;

    always_comb
    begin
        state_next     = state_reg;
        prev_year_next = prev_year_reg;
        month_next     = month_reg;
        cent_next      = cent_reg;
        count_next     = count_reg;
        ndays_next     = ndays_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ok)
                begin
                    prev_year_next = year_value - 14'd1;
                    month_next     = month_value;
                    state_next     = F_MUL;
                end
            end
            F_MUL:
            begin
                cent_next  = {6'd0, product[26:RECIP_SHIFT]};
                state_next = F_SUM;
            end
            F_SUM:
            begin
                count_next = {2'd0, prev_year_reg} + leaps
                           + {13'd0, month_shift(month_reg)}
                           + {15'd0, leap && (month_reg > MONTH_FEB)} - DAY_OFFSET;
                ndays_next = month_len(month_reg, leap);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        prev_year_reg <= prev_year_next;
        month_reg     <= month_next;
        cent_reg      <= cent_next;
        count_reg     <= count_next;
        ndays_reg     <= ndays_next;
    end

endmodule

// ----- src/mcg_queue.sv -----
// Short queue of grid requests between front and back parts.
// Uses mcg_pkg for the request record and depth.
module mcg_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  mcg_pkg::grid_req_t push_req,
    output logic               full,
    input  logic               pop,
    output mcg_pkg::grid_req_t pop_req,
    output logic               empty
);
    import mcg_pkg::*;

    localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

    grid_req_t          mem [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full    = (count_reg == CNT_W'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign pop_req = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- src/mcg_back.sv -----
// Back part: walks one request's grid into an output register, a cell per
// cycle unless out_ready stalls. Uses mcg_pkg for the request record and widths.
module mcg_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      empty,
    input  mcg_pkg::grid_req_t        pop_req,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [mcg_pkg::DAY_W-1:0] cell_day,
    output logic [mcg_pkg::COL_W-1:0] cell_column,
    output logic                      row_end,
    output logic                      grid_last
);
    import mcg_pkg::*;

    logic                active_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    lead_reg;
    logic [CELL_W-1:0]   span_reg;       // lead blanks plus days
    logic                out_valid_reg;
    logic [DAY_W-1:0]    day_out_reg;
    logic [COL_W-1:0]    col_out_reg;
    logic                last_out_reg;

    logic                fire;
    logic                is_last;
    logic [CELL_W-1:0]   day_calc;
    logic [DAY_W-1:0]    day_now;

    assign pop      = !active_reg && !empty;
    assign fire     = active_reg && (!out_valid_reg || out_ready);
    assign is_last  = (col_reg == LAST_COL) && ((cell_reg + 1'b1) >= span_reg);
    assign day_calc = cell_reg - {3'd0, lead_reg} + 1'b1;
    assign day_now  = ((cell_reg >= {3'd0, lead_reg}) && (cell_reg < span_reg))
                    ? day_calc[DAY_W-1:0] : '0;

    assign out_valid   = out_valid_reg;
    assign cell_day    = day_out_reg;
    assign cell_column = col_out_reg;
    assign row_end     = (col_out_reg == LAST_COL);
    assign grid_last   = last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            cell_reg      <= '0;
            col_reg       <= '0;
        end
        else
        begin
            if (pop)
            begin
                active_reg <= 1'b1;
                cell_reg   <= '0;
                col_reg    <= '0;
            end
            else if (fire)
            begin
                active_reg <= !is_last;
                cell_reg   <= cell_reg + 1'b1;
                col_reg    <= (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            lead_reg <= pop_req.lead;
            span_reg <= {3'd0, pop_req.lead} + {1'b0, pop_req.ndays};
        end
        if (fire)
        begin
            day_out_reg  <= day_now;
            col_out_reg  <= col_reg;
            last_out_reg <= is_last;
        end
    end

endmodule

// ----- tb/mcg_grid_checker.sv -----
`timescale 1ns / 1ps
// Checker for the month calendar grid generator: watches both stream channels,
// predicts the grid cells of every well-formed accepted request and compares them. Uses mcg_pkg.
module mcg_grid_checker
    import mcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [13:0] year_value, [17:14] month_value, rest zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [4:0] cell_day, [7:5] cell_column, [8] row_end
    input  logic        m_axis_tlast,   // grid_last
    output int          fail_count,
    output int          cells_pending
);

    localparam int unsigned WEEK_DAYS  = 7;
    localparam int unsigned GRID_CELLS = 42;
    localparam int unsigned FIRST_WDAY = 5;   // 1 January 1582 was a Friday

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [COL_W-1:0] column;
        logic             row_end;
        logic             grid_last;
    } grid_cell_t;

    grid_cell_t expected_cells[$];

    initial
    begin
        fail_count    = 0;
        cells_pending = 0;
    end

    function automatic bit is_leap(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned leap_years_upto(input int unsigned n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int unsigned days_of_month(input int unsigned y, input int unsigned m);
        int unsigned d;
        case (m)
            2:       d = is_leap(y) ? 29 : 28;
            4, 6, 9, 11: d = 30;
            default: d = 31;
        endcase
        return d;
    endfunction

    // Weekday of the 1st, counting whole days from the start of 1582.
    function automatic int unsigned first_column(input int unsigned y, input int unsigned m);
        int unsigned days;
        days = 365 * (y - BASE_YEAR) + leap_years_upto(y - 1) - leap_years_upto(BASE_YEAR - 1);
        for (int unsigned i = 1; i < m; i++)
            days += days_of_month(y, i);
        return (days + FIRST_WDAY) % WEEK_DAYS;
    endfunction

    task automatic push_grid(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
        int unsigned lead;
        int unsigned ndays;
        int unsigned ncells;
        grid_cell_t  c;
        // Requests the block discards leave nothing to wait for.
        if (m < 1 || m > MONTH_DEC || y < BASE_YEAR)
            return;
        lead   = first_column(y, m);
        ndays  = days_of_month(y, m);
        ncells = ((lead + ndays + WEEK_DAYS - 1) / WEEK_DAYS) * WEEK_DAYS;
        if (ncells > GRID_CELLS)
            ncells = GRID_CELLS;
        for (int unsigned k = 0; k < ncells; k++)
        begin
            c.day       = (k >= lead && k - lead < ndays) ? DAY_W'(k - lead + 1) : '0;
            c.column    = COL_W'(k % WEEK_DAYS);
            c.row_end   = (k % WEEK_DAYS == WEEK_DAYS - 1);
            c.grid_last = (k + 1 == ncells);
            expected_cells.push_back(c);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin : watch
        grid_cell_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cells.size() == 0)
                    report_mismatch($sformatf("cell transfer with nothing pending, tdata %h",
                                              m_axis_tdata));
                else
                begin
                    want = expected_cells.pop_front();
                    if (m_axis_tdata[4:0] !== want.day)
                        report_mismatch($sformatf("cell_day %0d, expected %0d",
                                                  m_axis_tdata[4:0], want.day));
                    if (m_axis_tdata[7:5] !== want.column)
                        report_mismatch($sformatf("cell_column %0d, expected %0d",
                                                  m_axis_tdata[7:5], want.column));
                    if (m_axis_tdata[8] !== want.row_end)
                        report_mismatch($sformatf("row_end %b, expected %b",
                                                  m_axis_tdata[8], want.row_end));
                    if (m_axis_tlast !== want.grid_last)
                        report_mismatch($sformatf("tlast %b, expected %b",
                                                  m_axis_tlast, want.grid_last));
                    if (m_axis_tdata[15:9] !== '0)
                        report_mismatch($sformatf("padding bits %b not zero",
                                                  m_axis_tdata[15:9]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                push_grid(s_axis_tdata[13:0], s_axis_tdata[17:14]);
            cells_pending = expected_cells.size();
        end
    end

endmodule

// ----- tb/month_calendar_grid_generator_top_tb.sv -----
`timescale 1ns / 1ps
// Top of the month calendar grid generator testbench: clock, reset, request
// stimulus and receiver back-pressure. Depends on mcg_pkg and mcg_grid_checker.
module month_calendar_grid_generator_top_tb;
    import mcg_pkg::*;

    // A long receiver hold-off, well beyond what the front part and the
    // two-entry queue can absorb, so that s_axis_tready must drop.
    localparam int LONG_HOLD   = 400;
    // Cycles allowed after the last expected cell for stray output to show.
    localparam int TAIL_CYCLES = 24;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [23:0] s_axis_tdata  = '0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    int fail_count;
    int cells_pending;

    // Percentages of cycles in which the sender idles and the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The stimulus asks for a long hold-off by bumping hold_requests; the
    // receiver process notices the difference and counts the stretch itself.
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    month_calendar_grid_generator_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mcg_grid_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .cells_pending (cells_pending)
    );

    // Receiver: random stalls at the current rate, or a long hold-off when
    // one has been asked for.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (holds_served != hold_requests)
        begin
            holds_served  <= holds_served + 1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offers one request and returns at the edge where it is accepted. The
    // valid flag stays high on return, so back-to-back transfers need no
    // second assignment in the same step; the next call lowers it if it idles.
    task automatic send_request(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, m, y};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Sender pause: the valid flag drops and nothing is offered until every
    // cell predicted so far has been transferred.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (cells_pending == 0);
        @(posedge clk);
    endtask

    // Random requests: mostly well-formed, with a minority of bad months and
    // years before 1582 mixed in. Only well-formed requests count towards n,
    // since the block simply discards the others.
    task automatic send_random(input int n);
        int                done;
        int unsigned       pick;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        done = 0;
        while (done < n)
        begin
            pick = $urandom_range(99);
            // Half the picks take a year up to 2600; the other half span the whole field.
            y = (pick % 2 == 0) ? YEAR_W'($urandom_range(2600, BASE_YEAR))
                                : YEAR_W'($urandom_range(16383, BASE_YEAR));
            m = MONTH_W'($urandom_range(MONTH_DEC, 1));
            if (pick < 7)
            begin
                // Month zero or above December.
                m = MONTH_W'($urandom_range(3));
                if (m != 0)
                    m = m + MONTH_DEC;
            end
            else if (pick < 12)
                y = YEAR_W'($urandom_range(BASE_YEAR - 1));
            else
            begin
                if (pick < 24)
                    m = MONTH_FEB;   // weight February for the leap rules
                done++;
            end
            send_request(y, m);
        end
    endtask

    initial
    begin
        $display("%m: month calendar grid regression");
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests, without idling on either side.
        send_request(14'd1582, 4'd1);      // the counting origin itself
        send_request(14'd16383, 4'd15);    // every input bit high, bad month
        send_request(14'd16383, 4'd12);    // largest year the field holds
        send_request(14'd1581, 4'd12);     // one year too early
        send_request(14'd0, 4'd6);         // year zero
        send_request(14'd2000, 4'd0);      // month zero
        send_request(14'd2000, 4'd13);     // first month past December
        send_request(14'd2000, 4'd2);      // leap by the four-hundred rule
        send_request(14'd1900, 4'd2);      // century year, not a leap year
        send_request(14'd2024, 4'd2);      // ordinary leap year
        send_request(14'd2015, 4'd2);      // starts on Sunday: exactly four rows
        send_request(14'd2015, 4'd1);      // last day closes a row, no trailing blanks
        send_request(14'd2022, 4'd1);      // starts on Saturday: six full rows
        for (int mo = 1; mo <= 12; mo++)
            send_request(14'd2023, MONTH_W'(mo));
        wait_for_drain();

        // Phase one: no idling. The receiver is held off for a long stretch
        // while requests keep coming, so the queue fills and input stalls.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = hold_requests + 1;
        send_random(80);
        wait_for_drain();

        // Phase two: the sender idles.
        send_idle_pct  = 57;
        recv_stall_pct = 0;
        send_random(77);
        wait_for_drain();

        // Phase three: the receiver stalls.
        send_idle_pct  = 0;
        recv_stall_pct = 57;
        send_random(77);
        wait_for_drain();

        // Phase four: both sides idle now and then.
        send_idle_pct  = 33;
        recv_stall_pct = 33;
        send_random(76);
        wait_for_drain();

        // Give any stray cell time to appear after the last expected one.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every grid at
    // six rows and both sides stalling.
    initial
    begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
